// File: rtl/tkr_pkg.sv
// Shared types and constants of the timed key release scheduler.
// Depends on nothing; tkr_alloc, the core and the bench import it.
package tkr_pkg;

   localparam int SLOTS       = 8;
   localparam int MAX_RESULTS = 8;
   localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [2:0] CMD_TICK        = 3'd0;
   localparam logic [2:0] CMD_TAP         = 3'd1;
   localparam logic [2:0] CMD_COMBO       = 3'd2;
   localparam logic [2:0] CMD_KEY_DOWN    = 3'd3;
   localparam logic [2:0] CMD_KEY_UP      = 3'd4;
   localparam logic [2:0] CMD_RELEASE_ALL = 3'd5;

   localparam logic [1:0] ACT_NONE        = 2'd0;
   localparam logic [1:0] ACT_PRESS       = 2'd1;
   localparam logic [1:0] ACT_RELEASE     = 2'd2;
   localparam logic [1:0] ACT_RELEASE_ALL = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] now_ms;
      logic [7:0]  key_a;
      logic [7:0]  key_b;
      logic [31:0] hold_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] key;
      logic       accepted;
      logic       last;
   } rsp_type;

   // One slot entry as held in the slot memory.
   typedef struct packed {
      logic [7:0]  key;
      logic [31:0] deadline;
   } entry_type;

   // Free-slot search result.
   typedef struct packed {
      logic             one_free;
      logic             two_free;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] second;
   } alloc_type;

endpackage

// File: rtl/tkr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module tkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tkr_alloc.sv
// Free-slot search: lowest and second-lowest idle slot from the busy bits.
// Depends on tkr_pkg.
module tkr_alloc (
   input  logic [tkr_pkg::SLOTS-1:0] busy,
   output tkr_pkg::alloc_type        alloc
);
   import tkr_pkg::*;

   always_comb begin
      alloc = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!busy[i]) begin
            if (!alloc.one_free) begin
               alloc.one_free = 1'b1;
               alloc.first    = IDX_W'(i);
            end else if (!alloc.two_free) begin
               alloc.two_free = 1'b1;
               alloc.second   = IDX_W'(i);
            end
         end
      end
   end

endmodule

// File: rtl/timed_key_release_scheduler_core.sv
// Timed key release scheduler, top level: sequencer, busy bits, output word.
// Depends on tkr_pkg, tkr_ram and tkr_alloc.
//
// Sequencing: key down, tap, release all and refused commands go from idle to the final
// state, combo passes its second claim state first, tick and key up walk the slot table
// (one slot memory read a cycle, pipelined, unless a tick waits on a full output word).
// One item is in work at a time; the input is stalled until its last word is stored.
// Reset clears the busy bits and the sequencer at once; the slot memory holds
// key and deadline, is not cleared; it is read for every slot but used only for busy ones.
module timed_key_release_scheduler_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tkr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tkr_pkg::rsp_type rsp_data
);
   import tkr_pkg::*;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_COMBO = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [SLOTS-1:0] busy_ff, busy_in;
   req_type          req_ff, req_in;
   logic [31:0]      deadline_ff, deadline_in;
   logic             ok_ff, ok_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] second_ff, second_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [7:0]       hold_key_ff, hold_key_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic             can_push;
   logic             push;
   rsp_type          push_word;
   logic [31:0]      req_deadline;
   alloc_type        alloc;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [$bits(entry_type)-1:0] rd_bits;
   entry_type        rd_entry;
   logic [31:0]      age;
   logic             hit;
   logic             scan_hold;
   logic             is_tick;

   // Slot memory: key and deadline of each slot.
   tkr_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   tkr_alloc u_alloc (
      .busy  (busy_ff),
      .alloc (alloc)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign can_push     = !rsp_valid_ff || !rsp_stall;
   assign req_deadline = req_data.now_ms + req_data.hold_ms;
   assign rd_entry     = entry_type'(rd_bits);
   assign is_tick      = (req_ff.command == CMD_TICK);

   // Wrap-safe expiry: the slot has expired when now - deadline is not negative.
   assign age = req_ff.now_ms - rd_entry.deadline;
   always_comb begin
      if (is_tick) begin
         hit = busy_ff[idx_ff] && !age[31] && (count_ff < CNT_W'(MAX_RESULTS));
      end else begin
         hit = busy_ff[idx_ff] && (rd_entry.key == req_ff.key_a);
      end
   end

   // A tick hit pushes the previously held release; wait if the output word is full.
   assign scan_hold = is_tick && hit && hold_valid_ff && !can_push;

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      req_in        = req_ff;
      deadline_in   = deadline_ff;
      ok_in         = ok_ff;
      idx_in        = idx_ff;
      second_in     = second_ff;
      hold_valid_in = hold_valid_ff;
      hold_key_in   = hold_key_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      wr_addr       = alloc.first;
      wr_entry      = '{key: req_data.key_a, deadline: req_deadline};
      rd_en         = 1'b0;
      rd_addr       = '0;
      push          = 1'b0;
      push_word     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in        = req_data;
               deadline_in   = req_deadline;
               ok_in         = 1'b0;
               idx_in        = '0;
               hold_valid_in = 1'b0;
               count_in      = '0;
               state_in      = ST_FIN;
               case (req_data.command)
                  CMD_TICK, CMD_KEY_UP: begin
                     // Start the table walk at slot zero.
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = ST_SCAN;
                  end
                  CMD_TAP: begin
                     if (alloc.one_free) begin
                        wr_en                = 1'b1;
                        busy_in[alloc.first] = 1'b1;
                        ok_in                = 1'b1;
                     end
                  end
                  CMD_COMBO: begin
                     // Claim the lower slot now, the higher one next cycle.
                     if (alloc.two_free) begin
                        wr_en                = 1'b1;
                        busy_in[alloc.first] = 1'b1;
                        second_in            = alloc.second;
                        ok_in                = 1'b1;
                        state_in             = ST_COMBO;
                     end
                  end
                  CMD_RELEASE_ALL: begin
                     busy_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!scan_hold) begin
               if (hit) begin
                  busy_in[idx_ff] = 1'b0;
                  if (is_tick) begin
                     // Hold this release back so the final one can carry last.
                     if (hold_valid_ff) begin
                        push      = 1'b1;
                        push_word = '{action: ACT_RELEASE, key: hold_key_ff,
                                      accepted: 1'b1, last: 1'b0};
                     end
                     hold_valid_in = 1'b1;
                     hold_key_in   = rd_entry.key;
                     count_in      = count_ff + 1'b1;
                  end
               end
               if (idx_ff == IDX_W'(SLOTS - 1)) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         ST_COMBO: begin
            // Rewriting the second slot while waiting is harmless.
            wr_en             = 1'b1;
            wr_addr           = second_ff;
            wr_entry          = '{key: req_ff.key_b, deadline: deadline_ff};
            busy_in[second_ff] = 1'b1;
            if (can_push) begin
               push      = 1'b1;
               push_word = '{action: ACT_PRESS, key: req_ff.key_a,
                             accepted: 1'b1, last: 1'b0};
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            if (can_push) begin
               push     = 1'b1;
               state_in = ST_IDLE;
               case (req_ff.command)
                  CMD_TICK: begin
                     if (hold_valid_ff) begin
                        push_word = '{action: ACT_RELEASE, key: hold_key_ff,
                                      accepted: 1'b1, last: 1'b1};
                     end else begin
                        push_word = '{action: ACT_NONE, key: 8'd0,
                                      accepted: 1'b1, last: 1'b1};
                     end
                  end
                  CMD_TAP: begin
                     if (ok_ff) begin
                        push_word = '{action: ACT_PRESS, key: req_ff.key_a,
                                      accepted: 1'b1, last: 1'b1};
                     end else begin
                        push_word = '{action: ACT_NONE, key: 8'd0,
                                      accepted: 1'b0, last: 1'b1};
                     end
                  end
                  CMD_COMBO: begin
                     if (ok_ff) begin
                        push_word = '{action: ACT_PRESS, key: req_ff.key_b,
                                      accepted: 1'b1, last: 1'b1};
                     end else begin
                        push_word = '{action: ACT_NONE, key: 8'd0,
                                      accepted: 1'b0, last: 1'b1};
                     end
                  end
                  CMD_KEY_DOWN: begin
                     push_word = '{action: ACT_PRESS, key: req_ff.key_a,
                                   accepted: 1'b1, last: 1'b1};
                  end
                  CMD_KEY_UP: begin
                     push_word = '{action: ACT_RELEASE, key: req_ff.key_a,
                                   accepted: 1'b1, last: 1'b1};
                  end
                  CMD_RELEASE_ALL: begin
                     push_word = '{action: ACT_RELEASE_ALL, key: 8'd0,
                                   accepted: 1'b1, last: 1'b1};
                  end
                  default: begin
                     push_word = '{action: ACT_NONE, key: 8'd0,
                                   accepted: 1'b0, last: 1'b1};
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output word: load on push, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = push_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= '0;
         hold_valid_ff <= 1'b0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         hold_valid_ff <= hold_valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      deadline_ff <= deadline_in;
      ok_ff       <= ok_in;
      idx_ff      <= idx_in;
      second_ff   <= second_in;
      hold_key_ff <= hold_key_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Never release more slots on one tick than a tick may report.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RESULTS))
      else $error("release count beyond limit");

   // A held release implies at least one slot was counted.
   a_hold_count: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (count_ff != '0))
      else $error("held release without count");

   // The closing word of an item comes only from the final state.
   a_last_fin: assert property (@(posedge clock) disable iff (reset)
      (push && push_word.last) |-> (state_ff == ST_FIN))
      else $error("last word pushed outside final state");

   // A successful combo enters its second claim state, and the second slot is busy in the cycle after.
   a_combo_next: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.command == CMD_COMBO && alloc.two_free)
         |=> (state_ff == ST_COMBO) ##1 busy_ff[second_ff])
      else $error("combo second claim missed");

endmodule

// File: test/timed_key_release_scheduler_core_tb.sv
// Self-checking bench for timed_key_release_scheduler_core: a directed table, then random
// command streams, each result word checked against a typed word or a behavioural slot
// table kept here. Depends on tkr_pkg and on the core RTL only.
`timescale 1ns / 100ps

module timed_key_release_scheduler_core_tb;
   import tkr_pkg::*;

   // Command codes the block does not define; it must refuse them.
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam logic TYPED     = 1'b1;   // expected word typed into the table
   localparam logic PREDICTED = 1'b0;   // expected words worked out by the slot table

   localparam int RANDOM_WORDS   = 300;
   localparam int TAIL_CYCLES    = 2 * (SLOTS + 2);
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PRINT_LIMIT    = 100;

   typedef struct packed {
      logic    typed;
      rsp_type want;
   } check_row_type;

   typedef struct packed {
      req_type w;
      logic    typed;
      rsp_type want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Slot table as the bench believes it to be.
   logic        held_busy [SLOTS];
   logic [7:0]  held_key  [SLOTS];
   logic [31:0] held_due  [SLOTS];

   rsp_type       step_words[$];    // words caused by the item being predicted
   rsp_type       awaited[$];       // words still to come back, oldest first
   check_row_type row_checks[$];    // one entry per word offered on the request side
   plan_row_type  directed_plan[$];

   int            mismatches = 0;
   int            idle_cycles = 0;
   logic          send_calm = 1'b0;
   logic          stall_calm = 1'b0;
   int            stall_left = 0;
   int            stall_roll;
   int            cycle_count = 0;
   rsp_type       want_word;
   check_row_type row_now;

   timed_key_release_scheduler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   initial begin
      foreach (held_busy[i]) begin
         held_busy[i] = 1'b0;
         held_key[i]  = 8'd0;
         held_due[i]  = 32'd0;
      end
   end

   // Print one line per mismatch (up to a cap) and count every one.
   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      if (mismatches < PRINT_LIMIT)
         $display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic void add_action(input logic [1:0] act, input logic [7:0] key,
                                      input logic ok);
      rsp_type r;
      r.action   = act;
      r.key      = key;
      r.accepted = ok;
      r.last     = 1'b0;
      step_words.push_back(r);
   endfunction

   // Work out the words one command causes and advance the slot table.
   task automatic predict_actions(input req_type w);
      logic [31:0] due;
      logic [31:0] lag;
      int          lowest;
      int          next_free;
      int          i;
      rsp_type     r;
      step_words.delete();
      due       = w.now_ms + w.hold_ms;
      lowest    = -1;
      next_free = -1;
      // Find the two lowest free slots up front; tap uses the lowest, combo both.
      for (i = 0; i < SLOTS; i++) begin
         if (!held_busy[i]) begin
            if (lowest < 0) lowest = i;
            else if (next_free < 0) next_free = i;
         end
      end
      case (w.command)
         CMD_TICK: begin
            // Expired means now minus deadline is not negative as a signed 32-bit value.
            for (i = 0; i < SLOTS; i++) begin
               lag = w.now_ms - held_due[i];
               if (held_busy[i] && !lag[31] && step_words.size() < MAX_RESULTS) begin
                  add_action(ACT_RELEASE, held_key[i], 1'b1);
                  held_busy[i] = 1'b0;
               end
            end
            if (step_words.size() == 0) add_action(ACT_NONE, 8'd0, 1'b1);
         end
         CMD_TAP: begin
            if (lowest >= 0) begin
               held_busy[lowest] = 1'b1;
               held_key[lowest]  = w.key_a;
               held_due[lowest]  = due;
               add_action(ACT_PRESS, w.key_a, 1'b1);
            end else begin
               add_action(ACT_NONE, 8'd0, 1'b0);
            end
         end
         CMD_COMBO: begin
            // Claim nothing unless both slots are there.
            if (next_free >= 0) begin
               held_busy[lowest]    = 1'b1;
               held_key[lowest]     = w.key_a;
               held_due[lowest]     = due;
               held_busy[next_free] = 1'b1;
               held_key[next_free]  = w.key_b;
               held_due[next_free]  = due;
               add_action(ACT_PRESS, w.key_a, 1'b1);
               add_action(ACT_PRESS, w.key_b, 1'b1);
            end else begin
               add_action(ACT_NONE, 8'd0, 1'b0);
            end
         end
         CMD_KEY_DOWN: add_action(ACT_PRESS, w.key_a, 1'b1);
         CMD_KEY_UP: begin
            // Cancel every pending release of this key, duplicates included.
            for (i = 0; i < SLOTS; i++)
               if (held_busy[i] && held_key[i] == w.key_a) held_busy[i] = 1'b0;
            add_action(ACT_RELEASE, w.key_a, 1'b1);
         end
         CMD_RELEASE_ALL: begin
            for (i = 0; i < SLOTS; i++) held_busy[i] = 1'b0;
            add_action(ACT_RELEASE_ALL, 8'd0, 1'b1);
         end
         default: add_action(ACT_NONE, 8'd0, 1'b0);
      endcase
      // Flag the final word of the item.
      r = step_words.pop_back();
      r.last = 1'b1;
      step_words.push_back(r);
   endtask

   // Watch both channels at each rising edge. Sample before the edge's updates land,
   // so check result words first: none can belong to an item accepted at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               report("unawaited word", 32'(rsp_data), 32'd0);
            end else begin
               want_word = awaited.pop_front();
               if (rsp_data.action !== want_word.action)
                  report("action", 32'(rsp_data.action), 32'(want_word.action));
               if (rsp_data.key !== want_word.key)
                  report("key", 32'(rsp_data.key), 32'(want_word.key));
               if (rsp_data.accepted !== want_word.accepted)
                  report("accepted", 32'(rsp_data.accepted), 32'(want_word.accepted));
               if (rsp_data.last !== want_word.last)
                  report("last", 32'(rsp_data.last), 32'(want_word.last));
            end
         end
         if (req_valid && !req_stall) begin
            predict_actions(req_data);
            row_now = (row_checks.size() != 0) ? row_checks.pop_front() : '0;
            // Typed rows carry their own single word; the slot table still advances.
            if (row_now.typed) awaited.push_back(row_now.want);
            else foreach (step_words[i]) awaited.push_back(step_words[i]);
         end
      end
   end

   // Stall the result side: mostly short bursts, now and then a long hold,
   // and calm stretches with no stall at all.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 0) stall_calm <= ($urandom_range(0, 3) == 0);
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_calm || stall_roll < 65) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
         end else if (stall_roll < 95) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(10, 40);
         end
      end
   end

   // Give up when neither channel has moved a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (send_calm || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one word, hold it until taken, then maybe idle for a while.
   task automatic send_word(input req_type w, input logic typed, input rsp_type want);
      check_row_type c;
      int            gap;
      c.typed = typed;
      c.want  = want;
      row_checks.push_back(c);
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every awaited word is back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited.size() != 0);
   endtask

   task automatic add_row(input logic [2:0] cmd, input logic [31:0] now, input logic [7:0] ka,
                          input logic [7:0] kb, input logic [31:0] hold, input logic typed,
                          input logic [1:0] act, input logic [7:0] key, input logic ok);
      plan_row_type p;
      p.w.command     = cmd;
      p.w.now_ms      = now;
      p.w.key_a       = ka;
      p.w.key_b       = kb;
      p.w.hold_ms     = hold;
      p.typed         = typed;
      p.want.action   = act;
      p.want.key      = key;
      p.want.accepted = ok;
      p.want.last     = 1'b1;
      directed_plan.push_back(p);
   endtask

   function automatic logic [7:0] pick_key();
      // Favour a few keys so that duplicates and key-up hits are common.
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 6));
   endfunction

   function automatic logic [31:0] pick_hold();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(0, 12);
      if (roll < 90) return $urandom();
      return 32'h7FFF_FFF8 + $urandom_range(0, 15);   // around the signed turnover
   endfunction

   initial begin
      req_type     w;
      rsp_type     none_word;
      int          k;
      int          roll;
      int          slot_pick;
      logic [31:0] sim_now;

      none_word = '0;

      // Fresh table: an empty tick, refused spare codes and key downs.
      add_row(CMD_TICK,     32'h0000_0000, 8'h00, 8'h00, 32'h0, TYPED, ACT_NONE, 8'h00, 1'b1);
      add_row(CMD_SPARE_6,  32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF,
              TYPED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_SPARE_7,  32'h0000_0000, 8'h00, 8'h00, 32'h0, TYPED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_KEY_DOWN, 32'h1234_5678, 8'hFF, 8'h00, 32'h0, TYPED, ACT_PRESS, 8'hFF, 1'b1);
      add_row(CMD_KEY_DOWN, 32'h0000_0000, 8'h00, 8'hFF, 32'h0, TYPED, ACT_PRESS, 8'h00, 1'b1);
      // Deadlines that wrap, a duplicate combo, a zero hold.
      add_row(CMD_TAP, 32'hFFFF_FFF0, 8'h00, 8'h00, 32'h20,
              PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_TAP, 32'hFFFF_FFFF, 8'hFF, 8'h00, 32'hFFFF_FFFF,
              PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_COMBO, 32'h0000_0000, 8'h11, 8'h11, 32'h7FFF_FFFF,
              PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_COMBO, 32'h0000_0000, 8'hAA, 8'h55, 32'h0,
              PREDICTED, ACT_NONE, 8'h00, 1'b0);
      // Deadline equal to now expires; a half-range-ahead one does not.
      add_row(CMD_TICK, 32'h0000_0000, 8'h00, 8'h00, 32'h0,
              PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_KEY_UP, 32'h0000_0000, 8'h11, 8'h00, 32'h0, TYPED, ACT_RELEASE, 8'h11, 1'b1);
      // Fill the table, then have tap and combo refused.
      add_row(CMD_COMBO, 32'h5, 8'h01, 8'h02, 32'h8000_0000, PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_COMBO, 32'h5, 8'h03, 8'h04, 32'hFFFF_FFFF, PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_COMBO, 32'h5, 8'h05, 8'h06, 32'h1,         PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_COMBO, 32'h5, 8'h07, 8'h08, 32'h1, TYPED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_TAP,   32'h5, 8'h09, 8'h00, 32'h2, PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_TAP,   32'h5, 8'h0A, 8'h00, 32'h2, TYPED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_COMBO, 32'h5, 8'h0B, 8'h0C, 32'h2, TYPED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_TICK,  32'h6, 8'h00, 8'h00, 32'h0, PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_RELEASE_ALL, 32'h7, 8'h00, 8'h00, 32'h0,
              TYPED, ACT_RELEASE_ALL, 8'h00, 1'b1);
      // Every slot due at once: one tick releases the lot.
      add_row(CMD_COMBO, 32'h4000_0000, 8'h21, 8'h22, 32'h0, PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_COMBO, 32'h4000_0000, 8'h23, 8'h24, 32'h0, PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_COMBO, 32'h4000_0000, 8'h25, 8'h26, 32'h0, PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_COMBO, 32'h4000_0000, 8'h27, 8'h28, 32'h0, PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_TICK,  32'h4000_0000, 8'h00, 8'h00, 32'h0, PREDICTED, ACT_NONE, 8'h00, 1'b0);
      add_row(CMD_KEY_UP, 32'h4000_0001, 8'h00, 8'h00, 32'h0,
              TYPED, ACT_RELEASE, 8'h00, 1'b1);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[n])
         send_word(directed_plan[n].w, directed_plan[n].typed, directed_plan[n].want);
      drain();

      // Random part: time creeps forward so holds expire under ticks, with the
      // odd jump anywhere in the 32-bit range.
      sim_now = $urandom();
      for (k = 0; k < RANDOM_WORDS; k++) begin
         if (k % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
         if (k == RANDOM_WORDS / 2) drain();
         if ($urandom_range(0, 99) < 4) sim_now = $urandom();
         else sim_now = sim_now + $urandom_range(0, 4);
         w.now_ms  = sim_now;
         w.key_a   = pick_key();
         w.key_b   = pick_key();
         w.hold_ms = pick_hold();
         roll = $urandom_range(0, 99);
         if (roll < 42)      w.command = CMD_TICK;
         else if (roll < 62) w.command = CMD_TAP;
         else if (roll < 76) w.command = CMD_COMBO;
         else if (roll < 82) w.command = CMD_KEY_DOWN;
         else if (roll < 91) begin
            // Aim key-up at a key that is pending, when one is there.
            w.command = CMD_KEY_UP;
            slot_pick = $urandom_range(0, SLOTS - 1);
            if (held_busy[slot_pick]) w.key_a = held_key[slot_pick];
         end
         else if (roll < 94) w.command = CMD_RELEASE_ALL;
         else if (roll < 97) w.command = 3'($urandom_range(0, 7));
         else w.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
         send_word(w, PREDICTED, none_word);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited.size() != 0) report("words never returned", 32'(awaited.size()), 32'd0);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
